// ===== hw/rtl/a2b_pkg.sv =====
// Package for the length-prefix to start-code converter: payload, state and code types.
package a2b_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SLEN   = 4'd1,
    PH_SFIRST = 4'd2,
    PH_SPAY   = 4'd3,
    PH_SPASS  = 4'd4,
    PH_RHDR   = 4'd5,
    PH_RSIZE  = 4'd6,
    PH_RPAY   = 4'd7,
    PH_RCOUNT = 4'd8,
    PH_RDONE  = 4'd9,
    PH_RPASS  = 4'd10
  } a2b_phase_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNIT_TRUNC  = 3'd1;
  localparam logic [2:0] ST_BAD_PREFIX  = 3'd2;
  localparam logic [2:0] ST_TRAIL_DROP  = 3'd3;
  localparam logic [2:0] ST_NOT_V1      = 3'd4;
  localparam logic [2:0] ST_REC_TRUNC   = 3'd5;

  localparam logic [0:0] CMD_SAMPLE = 1'b0;
  localparam logic [0:0] CMD_RECORD = 1'b1;

  localparam logic [7:0] PREFIX_MASK = 8'h03;
  localparam logic [7:0] COUNT_MASK  = 8'h1F;
  localparam logic [7:0] RECORD_VERSION = 8'h01;
  localparam logic [2:0] SAMPLE_PREFIX  = 3'd4;
  localparam logic [2:0] HDR_PREFIX_POS = 3'd4;
  localparam logic [2:0] HDR_COUNT_POS  = 3'd5;

  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_byte;
  } a2b_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       packet_end;
    logic [2:0] status;
  } a2b_out_t;

  typedef struct packed {
    logic [2:0]  prefix_size;
    a2b_phase_t  phase;
    logic [2:0]  hdr_pos;
    logic [31:0] unit_len;
    logic [31:0] bytes_left;
    logic [7:0]  units_left;
    logic [2:0]  err;
  } a2b_state_t;

  // Results caused by one request: optional start code, optional payload byte.
  typedef struct packed {
    logic       has_sc;
    logic       has_pay;
    logic [7:0] data;
    logic       pkt_end;
    logic [2:0] status;
  } a2b_burst_t;

endpackage

// ===== hw/rtl/a2b_step.sv =====
// Parser step: next state and result burst for one accepted input request.
module a2b_step (
  input  a2b_pkg::a2b_state_t st_cur,
  input  a2b_pkg::a2b_in_t    req,
  output a2b_pkg::a2b_state_t st_nxt,
  output a2b_pkg::a2b_burst_t burst,
  output logic                has_result
);
  import a2b_pkg::*;

  always_comb begin
    a2b_state_t s;
    logic       sc;
    logic       pay;
    logic       run;
    logic [2:0] end_st;
    logic [7:0] b;
    s   = st_cur;
    sc  = 1'b0;
    pay = 1'b0;
    run = 1'b1;
    b   = req.data_byte;

    if (s.phase == PH_IDLE) begin
      s.hdr_pos    = 3'd0;
      s.unit_len   = 32'd0;
      s.bytes_left = 32'd0;
      s.units_left = 8'd0;
      s.err        = ST_OK;
      if (req.cmd == CMD_RECORD) begin
        run = 1'b0;
        if (b != RECORD_VERSION) begin
          s.phase = PH_RPASS;
          s.err   = ST_NOT_V1;
          pay     = 1'b1;
        end else begin
          s.phase   = PH_RHDR;
          s.hdr_pos = 3'd1;
        end
      end else if (s.prefix_size == 3'd0) begin
        s.phase = PH_SPASS;
      end else if (s.prefix_size != SAMPLE_PREFIX) begin
        s.phase = PH_SPASS;
        s.err   = ST_BAD_PREFIX;
      end else begin
        s.phase = PH_SLEN;
      end
    end

    if (run) begin
      case (s.phase)
        PH_SLEN: begin
          s.unit_len = {s.unit_len[23:0], b};
          s.hdr_pos  = s.hdr_pos + 3'd1;
          if (s.hdr_pos >= 3'd4) s.phase = PH_SFIRST;
        end
        PH_SFIRST: begin
          sc           = 1'b1;
          s.bytes_left = s.unit_len;
          if (s.bytes_left == 32'd0) begin
            // Empty unit: this byte already opens the next length field.
            s.unit_len = {24'd0, b};
            s.hdr_pos  = 3'd1;
            s.phase    = PH_SLEN;
          end else begin
            pay          = 1'b1;
            s.bytes_left = s.bytes_left - 32'd1;
            if (s.bytes_left == 32'd0) begin
              s.phase    = PH_SLEN;
              s.hdr_pos  = 3'd0;
              s.unit_len = 32'd0;
            end else begin
              s.phase = PH_SPAY;
            end
          end
        end
        PH_SPAY: begin
          pay          = 1'b1;
          s.bytes_left = s.bytes_left - 32'd1;
          if (s.bytes_left == 32'd0) begin
            s.phase    = PH_SLEN;
            s.hdr_pos  = 3'd0;
            s.unit_len = 32'd0;
          end
        end
        PH_SPASS, PH_RPASS: begin
          pay = 1'b1;
        end
        PH_RHDR: begin
          if (s.hdr_pos == HDR_PREFIX_POS) begin
            s.prefix_size = {1'b0, b[1:0] & PREFIX_MASK[1:0]} + 3'd1;
            s.hdr_pos     = s.hdr_pos + 3'd1;
          end else if (s.hdr_pos == HDR_COUNT_POS) begin
            s.units_left = b & COUNT_MASK;
            s.hdr_pos    = 3'd0;
            s.phase      = (s.units_left == 8'd0) ? PH_RDONE : PH_RSIZE;
          end else begin
            s.hdr_pos = s.hdr_pos + 3'd1;
          end
        end
        PH_RSIZE: begin
          if (!s.hdr_pos[0]) begin
            s.unit_len = {24'd0, b};
            s.hdr_pos  = s.hdr_pos | 3'd1;
          end else begin
            s.unit_len   = {16'd0, s.unit_len[7:0], b};
            sc           = 1'b1;
            s.bytes_left = s.unit_len;
            s.hdr_pos    = 3'd0;
            if (s.bytes_left == 32'd0) begin
              s.units_left = s.units_left - 8'd1;
              s.phase      = (s.units_left == 8'd0) ? PH_RCOUNT : PH_RSIZE;
            end else begin
              s.phase = PH_RPAY;
            end
          end
        end
        PH_RPAY: begin
          pay          = 1'b1;
          s.bytes_left = s.bytes_left - 32'd1;
          if (s.bytes_left == 32'd0) begin
            s.units_left = s.units_left - 8'd1;
            s.hdr_pos    = 3'd0;
            s.phase      = (s.units_left == 8'd0) ? PH_RCOUNT : PH_RSIZE;
          end
        end
        PH_RCOUNT: begin
          s.units_left = b;
          s.hdr_pos    = 3'd4;
          s.phase      = (s.units_left == 8'd0) ? PH_RDONE : PH_RSIZE;
        end
        default: begin
        end
      endcase
    end

    // Closing status is judged on the state left after this byte.
    if (s.err != ST_OK) begin
      end_st = s.err;
    end else begin
      case (s.phase)
        PH_SPAY:          end_st = ST_UNIT_TRUNC;
        PH_SFIRST:        end_st = ST_TRAIL_DROP;
        PH_SLEN:          end_st = (s.hdr_pos != 3'd0) ? ST_TRAIL_DROP : ST_OK;
        PH_RHDR, PH_RPAY: end_st = ST_REC_TRUNC;
        PH_RSIZE:         end_st = s.hdr_pos[2] ? ST_OK : ST_REC_TRUNC;
        default:          end_st = ST_OK;
      endcase
    end

    if (req.last_byte) begin
      s.phase      = PH_IDLE;
      s.hdr_pos    = 3'd0;
      s.unit_len   = 32'd0;
      s.bytes_left = 32'd0;
      s.units_left = 8'd0;
      s.err        = ST_OK;
    end

    st_nxt        = s;
    burst.has_sc  = sc;
    burst.has_pay = pay;
    burst.data    = b;
    burst.pkt_end = req.last_byte;
    burst.status  = req.last_byte ? end_st : ST_OK;
    has_result    = sc | pay | req.last_byte;
  end

endmodule

// ===== hw/rtl/avcc_to_annexb_converter_core.sv =====
// Top level of the length-prefix to start-code converter: parser state and output serialiser.
// Latency: the first result of a request is offered in the cycle after it is accepted.
// Throughput: one request per cycle while each yields at most one result and the output does
// not stall; a request that opens a unit yields four start-code bytes (and maybe a payload
// byte), which the output serialiser delivers one result per cycle while not stalled.
// Reset (rst_n low, synchronous): parser returns to idle, prefix size clears, no result pending.
module avcc_to_annexb_converter_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  a2b_pkg::a2b_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output a2b_pkg::a2b_out_t out_data
);
  import a2b_pkg::*;

  // Parser state, updated the moment a request is accepted.
  a2b_state_t st_r;
  a2b_state_t st_nxt;

  // Pending burst of results for the request last accepted.
  a2b_burst_t burst_r;
  a2b_burst_t burst_nxt;
  logic       busy_r;
  logic [2:0] pos_r;

  logic       has_result;
  logic       accept;
  logic       take;
  logic       final_pos;
  logic [2:0] last_idx;
  logic       in_sc;

  a2b_step u_step (
    .st_cur     (st_r),
    .req        (in_data),
    .st_nxt     (st_nxt),
    .burst      (burst_nxt),
    .has_result (has_result)
  );

  // A start code occupies positions 0 to 3 and the payload byte, if any, follows it.
  // With neither present the burst is a single status-only marker.
  assign last_idx  = burst_r.has_sc ? (burst_r.has_pay ? 3'd4 : 3'd3) : 3'd0;
  assign final_pos = (pos_r == last_idx);
  assign take      = busy_r && !out_stall;

  // A new request is taken while the last result of the previous one leaves.
  assign in_stall = busy_r && !(take && final_pos);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      busy_r <= 1'b0;
      pos_r  <= 3'd0;
    end else begin
      if (accept) begin
        st_r <= st_nxt;
      end
      if (accept && has_result) begin
        busy_r <= 1'b1;
        pos_r  <= 3'd0;
      end else if (take) begin
        if (final_pos) begin
          busy_r <= 1'b0;
        end else begin
          pos_r <= pos_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      burst_r <= burst_nxt;
    end
  end

  assign in_sc = burst_r.has_sc && !pos_r[2];

  always_comb begin
    out_valid = busy_r;
    if (in_sc) begin
      out_data.out_byte  = START_CODE[pos_r[1:0]];
      out_data.out_valid = 1'b1;
    end else begin
      out_data.out_byte  = burst_r.has_pay ? burst_r.data : 8'd0;
      out_data.out_valid = burst_r.has_pay;
    end
    out_data.run_last   = final_pos;
    out_data.packet_end = final_pos && burst_r.pkt_end;
    out_data.status     = (final_pos && burst_r.pkt_end) ? burst_r.status : ST_OK;
  end

endmodule

// ===== sim/a2b_stream_checker.sv =====
`timescale 1ns / 1ps
// Stream checker for the start-code converter: predicts framed output and compares each result.
module a2b_stream_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  a2b_pkg::a2b_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  a2b_pkg::a2b_out_t out_data,
  output int                fail_count,
  output int                pending_count,
  output int                checked_count,
  output int                packet_count
);
  import a2b_pkg::*;

  localparam int REPORT_MAX = 30;

  // Parser state of the prediction.
  logic [2:0]  cur_prefix;
  a2b_phase_t  phase;
  logic [2:0]  hdr_pos;
  logic [31:0] unit_len;
  logic [31:0] bytes_rem;
  logic [7:0]  units_rem;
  logic [2:0]  err_code;

  a2b_out_t expected_stream [$];
  a2b_out_t step_res [5];
  int       step_n;

  int       n_fail;
  int       n_checked;
  int       n_packets;
  a2b_out_t want;

  function automatic void emit(input logic [7:0] b, input logic v);
    a2b_out_t r;
    if (step_n >= 5) return;
    r = '0;
    r.out_byte  = b;
    r.out_valid = v;
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic void emit_start_code();
    int k;
    for (k = 0; k < 4; k++) emit(START_CODE[k], 1'b1);
  endfunction

  function automatic void clear_parse();
    hdr_pos   = 3'd0;
    unit_len  = 32'd0;
    bytes_rem = 32'd0;
    units_rem = 8'd0;
    err_code  = ST_OK;
  endfunction

  function automatic void sample_next_length();
    phase    = PH_SLEN;
    hdr_pos  = 3'd0;
    unit_len = 32'd0;
  endfunction

  function automatic void record_unit_closed();
    units_rem = units_rem - 8'd1;
    hdr_pos   = 3'd0;
    phase     = (units_rem == 8'd0) ? PH_RCOUNT : PH_RSIZE;
  endfunction

  function automatic void advance_parser(input logic [7:0] b);
    logic [7:0] psize;
    case (phase)
      PH_SLEN: begin
        unit_len = {unit_len[23:0], b};
        hdr_pos  = hdr_pos + 3'd1;
        if (hdr_pos >= 3'd4) phase = PH_SFIRST;
      end
      PH_SFIRST: begin
        emit_start_code();
        bytes_rem = unit_len;
        if (bytes_rem == 32'd0) begin
          // An empty unit: this byte already opens the next length.
          unit_len = {24'd0, b};
          hdr_pos  = 3'd1;
          phase    = PH_SLEN;
        end else begin
          emit(b, 1'b1);
          bytes_rem = bytes_rem - 32'd1;
          if (bytes_rem == 32'd0) sample_next_length();
          else phase = PH_SPAY;
        end
      end
      PH_SPAY: begin
        emit(b, 1'b1);
        bytes_rem = bytes_rem - 32'd1;
        if (bytes_rem == 32'd0) sample_next_length();
      end
      PH_SPASS, PH_RPASS: emit(b, 1'b1);
      PH_RHDR: begin
        if (hdr_pos == HDR_COUNT_POS) begin
          units_rem = b & COUNT_MASK;
          hdr_pos   = 3'd0;
          phase     = (units_rem == 8'd0) ? PH_RDONE : PH_RSIZE;
        end else begin
          if (hdr_pos == HDR_PREFIX_POS) begin
            psize      = (b & PREFIX_MASK) + 8'd1;
            cur_prefix = psize[2:0];
          end
          hdr_pos = hdr_pos + 3'd1;
        end
      end
      PH_RSIZE: begin
        if (hdr_pos[0] == 1'b0) begin
          unit_len = {24'd0, b};
          hdr_pos  = hdr_pos | 3'd1;
        end else begin
          unit_len = {16'd0, unit_len[7:0], b};
          emit_start_code();
          bytes_rem = unit_len;
          hdr_pos   = 3'd0;
          if (bytes_rem == 32'd0) record_unit_closed();
          else phase = PH_RPAY;
        end
      end
      PH_RPAY: begin
        emit(b, 1'b1);
        bytes_rem = bytes_rem - 32'd1;
        if (bytes_rem == 32'd0) record_unit_closed();
      end
      PH_RCOUNT: begin
        units_rem = b;
        hdr_pos   = 3'd4;
        phase     = (units_rem == 8'd0) ? PH_RDONE : PH_RSIZE;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] closing_status();
    if (err_code != ST_OK) return err_code;
    case (phase)
      PH_SPAY:          return ST_UNIT_TRUNC;
      PH_SFIRST:        return ST_TRAIL_DROP;
      PH_SLEN:          return (hdr_pos != 3'd0) ? ST_TRAIL_DROP : ST_OK;
      PH_RHDR, PH_RPAY: return ST_REC_TRUNC;
      // Ending within the two size bytes after a later count is not an error.
      PH_RSIZE:         return hdr_pos[2] ? ST_OK : ST_REC_TRUNC;
      default:          return ST_OK;
    endcase
  endfunction

  function automatic void convert_byte(input a2b_in_t req);
    logic [2:0] st;
    int         k;
    step_n = 0;
    if (phase == PH_IDLE) begin
      clear_parse();
      if (req.cmd == CMD_RECORD) begin
        if (req.data_byte != RECORD_VERSION) begin
          phase    = PH_RPASS;
          err_code = ST_NOT_V1;
          emit(req.data_byte, 1'b1);
        end else begin
          phase   = PH_RHDR;
          hdr_pos = 3'd1;
        end
      end else begin
        if (cur_prefix == 3'd0) begin
          phase = PH_SPASS;
        end else if (cur_prefix != SAMPLE_PREFIX) begin
          phase    = PH_SPASS;
          err_code = ST_BAD_PREFIX;
        end else begin
          sample_next_length();
        end
        advance_parser(req.data_byte);
      end
    end else begin
      advance_parser(req.data_byte);
    end
    if (req.last_byte) begin
      st = closing_status();
      if (step_n == 0) emit(8'h00, 1'b0);
      step_res[step_n-1].packet_end = 1'b1;
      step_res[step_n-1].status     = st;
      phase = PH_IDLE;
      clear_parse();
      n_packets++;
    end
    if (step_n > 0) step_res[step_n-1].run_last = 1'b1;
    for (k = 0; k < step_n; k++) expected_stream.push_back(step_res[k]);
  endfunction

  initial begin
    n_fail    = 0;
    n_checked = 0;
    n_packets = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_prefix = 3'd0;
      phase      = PH_IDLE;
      clear_parse();
      expected_stream.delete();
    end else begin
      // Results seen at this edge come from earlier requests, so compare first.
      if (out_valid && !out_stall) begin
        if (expected_stream.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_MAX)
            $display("%0t: unexpected result: byte %h valid %b run_last %b end %b status %0d",
                     $time, out_data.out_byte, out_data.out_valid, out_data.run_last,
                     out_data.packet_end, out_data.status);
        end else begin
          want = expected_stream.pop_front();
          n_checked++;
          if (out_data.out_byte !== want.out_byte || out_data.out_valid !== want.out_valid ||
              out_data.run_last !== want.run_last || out_data.packet_end !== want.packet_end ||
              out_data.status !== want.status) begin
            n_fail++;
            if (n_fail <= REPORT_MAX)
              $display({"%0t: result %0d: expected byte %h valid %b run_last %b end %b ",
                        "status %0d, got byte %h valid %b run_last %b end %b status %0d"},
                       $time, n_checked, want.out_byte, want.out_valid, want.run_last,
                       want.packet_end, want.status, out_data.out_byte, out_data.out_valid,
                       out_data.run_last, out_data.packet_end, out_data.status);
          end
        end
      end
      if (in_valid && !in_stall) convert_byte(in_data);
    end
    fail_count    <= n_fail;
    pending_count <= expected_stream.size();
    checked_count <= n_checked;
    packet_count  <= n_packets;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, request stimulus, result sink and verdict.
module testbench;
  import a2b_pkg::*;

  // A request costs most when its five results meet the longest stalls, and even a run that
  // ends on a very long record needs only a fraction of this.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 350;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  a2b_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b1;
  a2b_out_t out_data;

  int fail_count;
  int pending_count;
  int checked_count;
  int packet_count;

  int cycles     = 0;
  int items_sent = 0;
  int src_calm   = 0;
  int sink_calm  = 0;

  // Bytes of the packet or record currently being assembled.
  logic [7:0] pkt_bytes [$];

  avcc_to_annexb_converter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a2b_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .packet_count  (packet_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses results.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [7:0] rnd_byte();
    int v;
    v = $urandom_range(0, 255);
    return v[7:0];
  endfunction

  // Idle length before the next request or result. Now and then a calm stretch is entered,
  // during which that side does not wait at all, so that back-to-back traffic is seen too.
  function automatic int draw_gap(inout int calm);
    int g;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
    case ($urandom_range(0, 3))
      0: g = $urandom_range(0, 16);
      1: g = $urandom_range(0, 3);
      default: g = 0;
    endcase
    return g;
  endfunction

  // Offers one request and returns at the edge at which it is accepted. Valid is only
  // lowered when a gap follows, so a back-to-back request keeps it high throughout.
  task automatic send_req(input logic c, input logic [7:0] d, input logic l);
    int      gap;
    a2b_in_t req;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.cmd       = c;
    req.data_byte = d;
    req.last_byte = l;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Sends the assembled bytes as one packet. Only the first byte's command counts, so the
  // later ones carry random commands. A random cut leaves a truncated packet.
  task automatic ship_packet(input logic kind, input logic may_cut);
    int   n;
    int   i;
    logic c;
    n = pkt_bytes.size();
    if (may_cut && n > 1 && $urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
    for (i = 0; i < n; i++) begin
      c = (i == 0) ? kind : logic'($urandom_range(0, 1));
      send_req(c, pkt_bytes[i], i == n - 1);
    end
  endtask

  // Unit sizes are mostly tiny to keep the run short, with an occasional long one.
  function automatic int draw_unit_size();
    int r;
    r = $urandom_range(0, 29);
    if (r == 0) return $urandom_range(256, 300);
    if (r < 4) return $urandom_range(7, 40);
    return $urandom_range(0, 6);
  endfunction

  task automatic add_record_unit();
    int sz;
    sz = draw_unit_size();
    pkt_bytes.push_back(sz[15:8]);
    pkt_bytes.push_back(sz[7:0]);
    repeat (sz) pkt_bytes.push_back(rnd_byte());
  endtask

  // A decoder configuration record: version, three profile bytes, the prefix-size byte,
  // the first group count, then units and possibly further groups.
  task automatic build_record();
    int         units;
    int         groups;
    int         pick;
    int         u;
    logic       more;
    logic [7:0] b;
    pkt_bytes.delete();
    pkt_bytes.push_back(RECORD_VERSION);
    repeat (3) pkt_bytes.push_back(rnd_byte());
    b = rnd_byte();
    // Favour a four-byte prefix so that later samples get parsed.
    if ($urandom_range(0, 9) < 6) b[1:0] = 2'b11;
    pkt_bytes.push_back(b);
    units = $urandom_range(0, 3);
    b = rnd_byte();
    b[4:0] = units[4:0];
    pkt_bytes.push_back(b);
    groups = 0;
    more   = 1'b1;
    while (more) begin
      for (u = 0; u < units; u++) add_record_unit();
      pick = $urandom_range(0, 5);
      more = 1'b0;
      if (pick < 2) begin
        // A zero count closes parsing; anything after it is ignored.
        pkt_bytes.push_back(8'h00);
        repeat ($urandom_range(0, 2)) pkt_bytes.push_back(rnd_byte());
      end else if (pick < 4 && groups < 2) begin
        units = $urandom_range(1, 2);
        pkt_bytes.push_back(units[7:0]);
        groups++;
        more = 1'b1;
      end else if (pick == 4) begin
        // A full-width count followed by at most part of one unit.
        pkt_bytes.push_back(rnd_byte());
        repeat ($urandom_range(0, 3)) pkt_bytes.push_back(rnd_byte());
      end
    end
  endtask

  // A length-prefixed sample of one to three units, sometimes with an overrunning length
  // or a short remainder left at the end.
  task automatic build_sample();
    int          units;
    int          u;
    int          pay;
    logic [31:0] len;
    pkt_bytes.delete();
    units = $urandom_range(1, 3);
    for (u = 0; u < units; u++) begin
      pay = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
      len = pay;
      if (u == units - 1 && $urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 0) len = pay + $urandom_range(1, 20);
        else len = {rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte()};
      end
      pkt_bytes.push_back(len[31:24]);
      pkt_bytes.push_back(len[23:16]);
      pkt_bytes.push_back(len[15:8]);
      pkt_bytes.push_back(len[7:0]);
      repeat (pay) pkt_bytes.push_back(rnd_byte());
    end
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) pkt_bytes.push_back(rnd_byte());
  endtask

  // The result side accepts one result per pass, after a random number of stalled cycles.
  initial begin : result_sink
    int gap;
    @(posedge clk);
    forever begin
      gap = draw_gap(sink_calm);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int   r;
    logic kind;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. After reset the prefix size is zero, so a sample passes straight through.
    pkt_bytes = '{8'h00, 8'hFF};
    ship_packet(CMD_SAMPLE, 1'b0);
    // A record whose version is not one passes through and leaves the prefix size alone.
    pkt_bytes = '{8'h02, 8'h55};
    ship_packet(CMD_RECORD, 1'b0);
    // A minimal record: four-byte prefix, one unit of one byte.
    pkt_bytes = '{8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF, 8'hE1, 8'h00, 8'h01, 8'hAB};
    ship_packet(CMD_RECORD, 1'b0);
    // A zero-length unit, whose fifth byte starts the next length, then a two-byte unit.
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hC3, 8'h3C};
    ship_packet(CMD_SAMPLE, 1'b0);
    // A lone byte is a remainder too short for a length and is dropped.
    pkt_bytes = '{8'hFF};
    ship_packet(CMD_SAMPLE, 1'b0);
    // A record that stops inside its header.
    pkt_bytes = '{8'h01, 8'h64, 8'h00};
    ship_packet(CMD_RECORD, 1'b0);

    // Random part: mostly well-formed records and samples with random content, the rest
    // malformed records and short noise packets.
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        build_sample();
        kind = CMD_SAMPLE;
      end else if (r < 7) begin
        build_record();
        kind = CMD_RECORD;
      end else if (r < 8) begin
        build_record();
        pkt_bytes[0] = rnd_byte();
        kind = CMD_RECORD;
      end else begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 6)) pkt_bytes.push_back(rnd_byte());
        kind = logic'($urandom_range(0, 1));
      end
      ship_packet(kind, 1'b1);
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow a few more cycles for strays.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests in %0d packets and compared %0d results.",
             items_sent, packet_count, checked_count);
    $display("Stimulus mixed records, samples, pass-through, truncated and malformed packets.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/a2b_pkg.sv
hw/rtl/a2b_step.sv
hw/rtl/avcc_to_annexb_converter_core.sv
sim/a2b_stream_checker.sv
sim/testbench.sv
